>>> rtl/core/rbwf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbwf_pkg
// Shared types and constants for the wrap-flag byte ring buffer.
// ----------------------------------------------------------------------------
package rbwf_pkg;

   // Default buffer depth and the per-request byte limit
   localparam int BUFFER_DEPTH_DEF = 8;
   localparam logic [2:0] MAX_PER_READ = 3'd7;

   typedef enum logic {
      ACTION_WRITE = 1'b0,
      ACTION_READ  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVF_WRITE = 2'd1,
      STATUS_OVF_READ  = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      action_type action;
      logic [7:0] data_byte_in;
      logic       burst_end;
      logic [7:0] read_count;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte_out;
      logic       byte_valid;
      status_type status;
      logic [2:0] delivered_total;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_FETCH,
      ST_EMIT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic take;
      logic push_single;
      logic push_byte;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic multi;
      logic last_byte;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

>>> rtl/core/rbwf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbwf_ctrl
// Sequencer: accepts one transaction at a time and steps the datapath
// through its single result or its byte-by-byte read.
// ----------------------------------------------------------------------------
module rbwf_ctrl
   import rbwf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  dp_status_type      status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = status.multi ? ST_FETCH : ST_SINGLE;
            end
         end
         ST_SINGLE: begin
            if (status.out_free) begin
               cmd.push_single = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         // wait for the registered store read
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.push_byte = 1'b1;
               state_in      = status.last_byte ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

>>> rtl/core/rbwf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbwf_dp
// Datapath: byte store, pointers, wrap flag, burst tracking and the
// output register.
// ----------------------------------------------------------------------------
module rbwf_dp
   import rbwf_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  req_type            req_payload,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_payload,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      status
);

   localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int AV_W  = (PTR_W + 1 > 3) ? PTR_W + 1 : 3;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(BUFFER_DEPTH);

   logic [7:0]       mem [BUFFER_DEPTH];
   logic [7:0]       rd_data_ff;

   logic [PTR_W-1:0] write_ptr_ff, write_ptr_in;
   logic [PTR_W-1:0] read_ptr_ff, read_ptr_in;
   logic [PTR_W-1:0] burst_start_ff, burst_start_in;
   logic             in_burst_ff, in_burst_in;
   logic             wrap_flag_ff, wrap_flag_in;
   status_type       single_status_ff, single_status_in;
   logic [2:0]       n_ff, n_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [PTR_W-1:0] wp_next;
   logic [PTR_W-1:0] rp_next;
   logic [PTR_W-1:0] start_ptr;
   logic [PTR_W:0]   avail;
   logic [AV_W-1:0]  avail_x;
   logic [2:0]       avail7;
   logic [2:0]       req7;
   logic [2:0]       n_calc;
   logic             is_write;
   logic             ovf_read;
   logic [2:0]       cnt_inc;

   // Pointer steps and occupancy
   always_comb begin
      wp_next   = (write_ptr_ff == PTR_LAST) ? '0 : write_ptr_ff + 1'b1;
      rp_next   = (read_ptr_ff == PTR_LAST) ? '0 : read_ptr_ff + 1'b1;
      start_ptr = in_burst_ff ? burst_start_ff : write_ptr_ff;
      if (write_ptr_ff >= read_ptr_ff) begin
         avail = {1'b0, write_ptr_ff} - {1'b0, read_ptr_ff};
      end else begin
         avail = {1'b0, write_ptr_ff} + DEPTH_X - {1'b0, read_ptr_ff};
      end
      avail_x  = AV_W'(avail);
      avail7   = (avail_x > AV_W'(MAX_PER_READ)) ? MAX_PER_READ : avail_x[2:0];
      req7     = (req_payload.read_count > 8'(MAX_PER_READ)) ?
                 MAX_PER_READ : req_payload.read_count[2:0];
      n_calc   = (req7 < avail7) ? req7 : avail7;
      is_write = (req_payload.action == ACTION_WRITE);
      ovf_read = wrap_flag_ff && (write_ptr_ff > read_ptr_ff);
      cnt_inc  = cnt_ff + 3'd1;
   end

   // Status towards the sequencer
   always_comb begin
      status.multi     = !is_write && !ovf_read && (avail != '0) && (n_calc != 3'd0);
      status.last_byte = (cnt_inc == n_ff);
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Next-state logic for pointers, flags and the output register
   always_comb begin
      write_ptr_in     = write_ptr_ff;
      read_ptr_in      = read_ptr_ff;
      burst_start_in   = burst_start_ff;
      in_burst_in      = in_burst_ff;
      wrap_flag_in     = wrap_flag_ff;
      single_status_in = single_status_ff;
      n_in             = n_ff;
      cnt_in           = cnt_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_in           = rsp_ff;

      if (cmd.take) begin
         if (is_write) begin
            // store, advance, and check the burst for a wrap on its last byte
            write_ptr_in     = wp_next;
            burst_start_in   = start_ptr;
            in_burst_in      = 1'b1;
            single_status_in = STATUS_OK;
            if (req_payload.burst_end) begin
               in_burst_in = 1'b0;
               if (wp_next < start_ptr) begin
                  if (wrap_flag_ff) begin
                     single_status_in = STATUS_OVF_WRITE;
                  end
                  wrap_flag_in = 1'b1;
               end
            end
         end else if (ovf_read) begin
            single_status_in = STATUS_OVF_READ;
         end else if (avail == '0) begin
            single_status_in = STATUS_EMPTY;
         end else begin
            single_status_in = STATUS_OK;
            n_in             = n_calc;
            cnt_in           = 3'd0;
         end
      end

      // present a one-result transaction
      if (cmd.push_single) begin
         rsp_valid_in           = 1'b1;
         rsp_in.data_byte_out   = 8'd0;
         rsp_in.byte_valid      = 1'b0;
         rsp_in.status          = single_status_ff;
         rsp_in.delivered_total = 3'd0;
         rsp_in.last            = 1'b1;
      end

      // present one byte and advance the read side
      if (cmd.push_byte) begin
         rsp_valid_in           = 1'b1;
         rsp_in.data_byte_out   = rd_data_ff;
         rsp_in.byte_valid      = 1'b1;
         rsp_in.status          = STATUS_OK;
         rsp_in.delivered_total = n_ff;
         rsp_in.last            = (cnt_inc == n_ff);
         read_ptr_in            = rp_next;
         cnt_in                 = cnt_inc;
         if (read_ptr_ff == PTR_LAST) begin
            wrap_flag_in = 1'b0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff   <= '0;
         read_ptr_ff    <= '0;
         burst_start_ff <= '0;
         in_burst_ff    <= 1'b0;
         wrap_flag_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         write_ptr_ff   <= write_ptr_in;
         read_ptr_ff    <= read_ptr_in;
         burst_start_ff <= burst_start_in;
         in_burst_ff    <= in_burst_in;
         wrap_flag_ff   <= wrap_flag_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      single_status_ff <= single_status_in;
      n_ff             <= n_in;
      cnt_ff           <= cnt_in;
      rsp_ff           <= rsp_in;
   end

   // Byte store: one write port, registered read at the read pointer
   always_ff @(posedge clock) begin
      if (cmd.take && is_write) begin
         mem[write_ptr_ff] <= req_payload.data_byte_in;
      end
      rd_data_ff <= mem[read_ptr_ff];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

>>> rtl/core/ring_buffer_wrap_flag.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_buffer_wrap_flag
// Byte ring buffer with a wrap flag in place of a byte count.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A write, or a read that reports
// overflow, empty or zero bytes, is accepted and then has its single
// result loaded into the output register once that register is free. A
// read that delivers n bytes (n at most 7) fetches each byte from the
// byte store through its registered read port and then loads it into the
// output register once that register is free. The output register lets a result
// wait for the consumer while the next transaction is accepted once the
// current one has finished. The byte store needs no clearing after reset.
// ----------------------------------------------------------------------------
module ring_buffer_wrap_flag
   import rbwf_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  req_type            req_payload,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_payload
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   rbwf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rbwf_dp #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
`default_nettype wire
